/* rtl/core/b64e_pkg.sv */
// Shared types, character constants and the sextet alphabet for the Base64 encoder.
package b64e_pkg;

    // ASCII line feed and pad characters
    localparam logic [7:0] LF_CHAR       = 8'd10;
    localparam logic [7:0] PAD_CHAR      = 8'd61;
    // line length after reset
    localparam logic [7:0] LINE_LEN_INIT = 8'd76;

    // one classified input byte: up to four characters to send, in order
    typedef struct packed {
        logic [3:0][7:0] chars;   // chars[0] goes out first
        logic [1:0]      cnt_m1;  // number of characters minus one
        logic            eom;     // message ends after this group
    } t_job;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = w + 8'd65;
        end else if (v < 6'd52) begin
            c = w + 8'd71;
        end else if (v < 6'd62) begin
            c = w - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'd43;
        end else begin
            c = 8'd47;
        end
        return c;
    endfunction

endpackage

/* rtl/core/b64e_front.sv */
// Front end: takes input beats, tracks the 3-byte grouping and builds character jobs.
module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0] r_phase;
    logic [1:0] n_phase;
    logic [3:0] r_left;
    logic [3:0] n_left;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // split the byte into sextets according to the group phase
    always_comb begin
        o_job       = '0;
        o_job.eom   = i_end_of_message;
        n_phase     = r_phase;
        n_left      = r_left;
        case (r_phase)
            2'd1: begin
                o_job.chars[0] = sextet_char({r_left[1:0], i_data_byte[7:4]});
                n_left  = i_data_byte[3:0];
                n_phase = 2'd2;
                if (i_end_of_message) begin
                    o_job.chars[1] = sextet_char({i_data_byte[3:0], 2'b00});
                    o_job.chars[2] = PAD_CHAR;
                    o_job.cnt_m1   = 2'd2;
                end
            end
            2'd2: begin
                o_job.chars[0] = sextet_char({r_left, i_data_byte[7:6]});
                o_job.chars[1] = sextet_char(i_data_byte[5:0]);
                o_job.cnt_m1   = 2'd1;
                n_left  = 4'd0;
                n_phase = 2'd0;
            end
            default: begin
                o_job.chars[0] = sextet_char(i_data_byte[7:2]);
                n_left  = {2'b00, i_data_byte[1:0]};
                n_phase = 2'd1;
                if (i_end_of_message) begin
                    o_job.chars[1] = sextet_char({i_data_byte[1:0], 4'b0000});
                    o_job.chars[2] = PAD_CHAR;
                    o_job.chars[3] = PAD_CHAR;
                    o_job.cnt_m1   = 2'd3;
                end
            end
        endcase
        // end of message closes the group
        if (i_end_of_message) begin
            n_phase = 2'd0;
            n_left  = 4'd0;
        end
    end

    // group state advances on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_left  <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule

/* rtl/core/b64e_queue.sv */
// Small flop-based queue of character jobs between front and back end.
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/b64e_back.sv */
// Back end: sends job characters one per beat, inserts line feeds, drives the output register.
module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_line_len,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run
);

    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;
    logic [7:0] r_col;
    logic [1:0] r_idx;
    logic       r_lf;
    logic       r_lf_last;

    logic       load;
    logic [7:0] col_inc;
    logic       need_lf;
    logic       is_last;

    assign o_valid       = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_last_of_run = r_out_last;

    // next beat is loaded when the output slot is free or draining
    assign load    = i_q_valid && (!r_out_valid || i_ready);
    assign col_inc = (r_col == 8'd255) ? r_col : r_col + 8'd1;
    assign need_lf = (i_line_len != 8'd0) && (col_inc >= i_line_len);
    assign is_last = (r_idx == i_q_job.cnt_m1);
    assign o_pop   = load && (r_lf ? r_lf_last : (is_last && !need_lf));

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_lf) begin
                r_out_char <= LF_CHAR;
                r_out_last <= r_lf_last;
            end else begin
                r_out_char <= i_q_job.chars[r_idx];
                r_out_last <= is_last && !need_lf;
            end
        end
    end

    // character sequencing and column count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_col       <= 8'd0;
            r_idx       <= 2'd0;
            r_lf        <= 1'b0;
            r_lf_last   <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                if (r_lf) begin
                    r_lf <= 1'b0;
                end else if (need_lf) begin
                    r_col     <= 8'd0;
                    r_lf      <= 1'b1;
                    r_lf_last <= is_last;
                    r_idx     <= is_last ? 2'd0 : r_idx + 2'd1;
                end else begin
                    r_col <= (is_last && i_q_job.eom) ? 8'd0 : col_inc;
                    r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
                end
            end
        end
    end

    // a pending line feed always sits behind a character still in the output slot
    a_lf_has_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lf |-> r_out_valid)
        else $error("line feed pending with empty output slot");

    // the job stays at the queue head until its line feed has gone
    a_lf_has_job : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lf |-> i_q_valid)
        else $error("line feed pending without a job");

    // character index stays within the job
    a_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_q_valid && !r_lf) |-> (r_idx <= i_q_job.cnt_m1))
        else $error("character index past end of job");

    // a job is only retired once its last beat is loaded
    a_pop_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_out_last))
        else $error("job retired without a last beat");

endmodule

/* rtl/core/base64_encoder_line_wrap.sv */
// Top level of the streaming Base64 encoder with line wrapping.
//
//  channel  | valid        | ready         | payload
//  ---------+--------------+---------------+---------------------------------
//  input    | i_valid      | o_ready       | i_data_byte, i_end_of_message
//  output   | o_valid      | i_ready       | o_out_char, o_last_of_run
//  config   | i_cfg_valid  | o_cfg_ready   | i_cfg_data (line length)
//
// An accepted byte is written into the job queue and from there into the output register.
// The back end sends one character per cycle while the output is ready; a byte gives
// 1 to 8 characters, line feeds included, and its share of the output is set by that count.
// The job queue holds Q_DEPTH bytes, so input and output stall independently.
// Synchronous active-low reset clears group state, column and queue; line length
// returns to 76. Config beats are always accepted.
module base64_encoder_line_wrap
    import b64e_pkg::*;
#(
    parameter int Q_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_line_len;
    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    t_job       push_job;
    t_job       head_job;

    // line length register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= LINE_LEN_INIT;
        end else if (i_cfg_valid) begin
            r_line_len <= i_cfg_data;
        end
    end

    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_job            (push_job)
    );

    b64e_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_len    (r_line_len),
        .i_q_valid     (q_valid),
        .i_q_job       (head_job),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* tb/b64e_stream_checker.sv */
// Checker for the Base64 line-wrap encoder: watches all three channels, predicts and compares.
module b64e_stream_checker
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte channel
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_eom,
    // character channel
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_char,
    input  logic       i_out_last,
    // line length register
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_chars_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [511:0] SEXTET_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int MAX_BURST = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    // predicted encoder state
    logic [7:0] line_len;
    logic [1:0] group_pos;
    logic [3:0] carry_bits;
    logic [7:0] column;

    // characters caused by the byte being predicted
    logic [7:0] burst_chars [MAX_BURST];
    int         burst_len;

    t_enc_char  expected_chars [$];
    t_enc_char  head;
    int         fail_count  = 0;
    int         pending_n   = 0;
    int         checked_n   = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_n;
    assign o_chars_checked = checked_n;

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        return SEXTET_ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    task automatic note_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic push_raw(input logic [7:0] ch);
        if (burst_len < MAX_BURST) begin
            burst_chars[burst_len] = ch;
            burst_len++;
        end
    endtask

    // one character onto the line, with a line feed once the line is full
    task automatic put_char(input logic [7:0] ch);
        push_raw(ch);
        if (column != 8'd255) begin
            column = column + 8'd1;
        end
        if (line_len != 8'd0 && column >= line_len) begin
            push_raw(LF_CHAR);
            column = 8'd0;
        end
    endtask

    task automatic put_sextet(input logic [5:0] v);
        put_char(sextet_to_ascii(v));
    endtask

    // work out every character one accepted byte causes, queue them in order
    task automatic predict_byte(input logic [7:0] b, input logic eom);
        burst_len = 0;
        case (group_pos)
            2'd1: begin
                put_sextet({carry_bits[1:0], b[7:4]});
                carry_bits = b[3:0];
                group_pos  = 2'd2;
            end
            2'd2: begin
                put_sextet({carry_bits, b[7:6]});
                put_sextet(b[5:0]);
                carry_bits = 4'd0;
                group_pos  = 2'd0;
            end
            default: begin
                put_sextet(b[7:2]);
                carry_bits = {2'b00, b[1:0]};
                group_pos  = 2'd1;
            end
        endcase
        // message end: close a partial group with padding, restart the line
        if (eom) begin
            if (group_pos == 2'd1) begin
                put_sextet({carry_bits[1:0], 4'b0000});
                put_char(PAD_CHAR);
                put_char(PAD_CHAR);
            end else if (group_pos == 2'd2) begin
                put_sextet({carry_bits, 2'b00});
                put_char(PAD_CHAR);
            end
            group_pos  = 2'd0;
            carry_bits = 4'd0;
            column     = 8'd0;
        end
        for (int i = 0; i < burst_len; i++) begin
            expected_chars.push_back('{ch: burst_chars[i], last: (i == burst_len - 1)});
        end
    endtask

    // sample all channels at the clock edge; result beats are matched first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_len   = LINE_LEN_INIT;
            group_pos  = 2'd0;
            carry_bits = 4'd0;
            column     = 8'd0;
            expected_chars.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    note_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                            i_out_char, i_out_last));
                end else begin
                    head = expected_chars.pop_front();
                    checked_n++;
                    if (head.ch !== i_out_char || head.last !== i_out_last) begin
                        note_mismatch($sformatf(
                            "char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                            head.ch, i_out_char, head.last, i_out_last));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                line_len = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_in_byte, i_in_eom);
            end
        end
        pending_n = expected_chars.size();
    end

endmodule

/* tb/base64_encoder_line_wrap_tb.sv */
// Top of the Base64 line-wrap encoder testbench: clock, reset, stimulus and verdict.
module base64_encoder_line_wrap_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import b64e_pkg::*;

    localparam int RANDOM_ITEMS = 20;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_TAIL   = 12;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       i_end_of_message;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_char;
    logic       o_last_of_run;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    int fail_count;
    int pending;
    int chars_checked;
    int beats_sent = 0;
    int cfg_writes = 0;
    int holds_done = 0;

    // idling controls for the sender and the receiver
    bit tx_throttle = 1'b0;
    bit rx_throttle = 1'b0;
    bit hold_req    = 1'b0;

    base64_encoder_line_wrap dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_char       (o_out_char),
        .o_last_of_run    (o_last_of_run),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    b64e_stream_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_byte       (i_data_byte),
        .i_in_eom        (i_end_of_message),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_out_char      (o_out_char),
        .i_out_last      (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_chars_checked (chars_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 0;
        end else if (r < 9) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // offer one byte beat and hold it until taken; valid stays up afterwards
    task automatic send_beat(input logic [7:0] d, input logic eom);
        int gap;
        gap = tx_throttle ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= d;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (!o_ready);
        beats_sent++;
    endtask

    task automatic send_message(input int len, input bit close);
        for (int i = 0; i < len; i++) begin
            send_beat(8'($urandom_range(0, 255)), close && (i == len - 1));
        end
    endtask

    // stop offering and wait for every predicted character, then a short tail
    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_line_length(input logic [7:0] v);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // receiver: random stalls, free-running stretches, and long hold-offs on request
    initial begin : rx_proc
        int stall;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else if (!rx_throttle) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // stimulus and verdict
    initial begin : stim_proc
        logic [7:0] len_pick;
        int         phase_n;
        int         budget;
        int         msg_len;
        int         random_start;

        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= 8'd0;
        i_end_of_message <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_data       <= 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_throttle = 1'b1;
        rx_throttle = 1'b1;

        // reset line length: two-byte tail, one-byte tail, whole group
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'hAA, 1'b1);
        send_beat(8'h4D, 1'b0);
        send_beat(8'h61, 1'b0);
        send_beat(8'h6E, 1'b1);

        // short lines: a line exactly full at message end still gets its feed
        write_line_length(8'd4);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h01, 1'b0);
        send_beat(8'h02, 1'b0);
        send_beat(8'h03, 1'b0);
        send_beat(8'h04, 1'b1);

        // one char per line: a padded single byte gives the longest burst
        write_line_length(8'd1);
        send_beat(8'hFF, 1'b1);

        // wrapping off
        write_line_length(8'd0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h11, 1'b0);
        send_beat(8'h22, 1'b0);
        send_beat(8'h33, 1'b0);
        send_beat(8'h44, 1'b1);

        // longest line, then cut short in the middle of a line
        write_line_length(8'd255);
        send_beat(8'h12, 1'b0);
        send_beat(8'h34, 1'b0);
        send_beat(8'h56, 1'b0);
        send_beat(8'h78, 1'b0);
        send_beat(8'h9A, 1'b0);
        send_beat(8'hBC, 1'b0);
        write_line_length(8'd3);
        send_beat(8'hDE, 1'b1);

        // unwrapped run past 255 chars: column must saturate, not wrap;
        // the receiver holds off meanwhile while bytes keep coming back to back
        write_line_length(8'd0);
        rx_throttle = 1'b0;
        tx_throttle = 1'b0;
        hold_req    = 1'b1;
        send_message(192, 1'b0);
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
        write_line_length(8'd255);
        send_beat(8'($urandom_range(0, 255)), 1'b1);

        // random phases, each under its own line length
        random_start = beats_sent;
        phase_n      = 0;
        while (beats_sent - random_start < RANDOM_ITEMS) begin
            case (phase_n)
                0:       len_pick = 8'd2;
                1:       len_pick = 8'd76;
                2:       len_pick = 8'd5;
                3:       len_pick = 8'd3;
                default: len_pick = 8'($urandom_range(0, 255));
            endcase
            write_line_length(len_pick);
            tx_throttle = ($urandom_range(0, 3) != 0);
            rx_throttle = ($urandom_range(0, 3) != 0);

            budget = $urandom_range(4, 8);
            while (budget > 0) begin
                msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 10)
                                                      : $urandom_range(1, 4);
                send_message(msg_len, $urandom_range(0, 9) != 0);
                budget -= msg_len;
                // sender pauses mid-phase until the output has caught up
                if (phase_n == 1 && budget > 0) begin
                    wait_drain();
                end
            end
            phase_n++;
        end

        wait_drain();
        $display("Covered %0d byte beats (%0d random) and %0d characters checked,",
                 beats_sent, beats_sent - random_start, chars_checked);
        $display("over %0d line-length writes and %0d long output hold-offs.",
                 cfg_writes, holds_done);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #(8_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_encoder_line_wrap.sv
tb/b64e_stream_checker.sv
tb/base64_encoder_line_wrap_tb.sv
